FILE: design/tdf_pkg.sv
// Package: constants, types and helpers for the trial-division factorizer
`default_nettype none
package tdf_pkg;

  localparam int ValueWidth  = 32;
  localparam int PrimeLimit  = 65536;
  localparam int TableDepth  = PrimeLimit / 2 + 2;
  localparam int NumWidth    = $clog2(PrimeLimit);
  localparam int IdxWidth    = $clog2(TableDepth);
  localparam int TotWidth    = IdxWidth + 1;
  localparam int ExpWidth    = 6;
  localparam int MaxResults  = 9;
  localparam int CntWidth    = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SIEVE_I,
    ST_SIEVE_RD,
    ST_SIEVE_LD,
    ST_SIEVE_CHK,
    ST_SIEVE_MOD,
    ST_IDLE,
    ST_FETCH,
    ST_SQUARE,
    ST_DIVIDE,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_TAIL,
    ST_OUT
  } tdf_state_t;

  typedef struct packed {
    logic [ValueWidth-1:0] prime_factor;
    logic [ExpWidth-1:0]   exponent;
    logic [ExpWidth-1:0]   total_exponents;
    logic                  empty_res;
    logic                  last;
  } tdf_result_t;

endpackage
`default_nettype wire

FILE: design/tdf_if.sv
// Interfaces: valid/ready channels for the input and result streams
`default_nettype none
interface tdf_in_if import tdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if import tdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] prime_factor;
  logic [ExpWidth-1:0]   exponent;
  logic [ExpWidth-1:0]   total_exponents;
  logic                  empty_res;
  logic                  last;
  modport source (output valid, output prime_factor, output exponent,
                  output total_exponents, output empty_res, output last, input ready);
  modport sink   (input valid, input prime_factor, input exponent,
                  input total_exponents, input empty_res, input last, output ready);
endinterface
`default_nettype wire

FILE: design/trial_division_factorizer_core.sv
// Top level: sieve-filled prime table and trial-division factorizer
//
//  channel | dir | handshake    | payload
//  in_     | in  | valid/ready  | value[31:0]
//  out_    | out | valid/ready  | prime_factor, exponent, total_exponents, empty_res, last
//
// After reset a clearing pass runs over all 65536 entries of the mark memory, then the
// linear sieve (one division in the shared divider per marking step); no input is
// taken until both finish. Each value then costs a table read per prime tried plus
// its divisions in the shared divider.
// Results are held in an output register until transferred; the next value is
// taken only after the last result of the current one has been transferred.
`default_nettype none
module trial_division_factorizer_core import tdf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tdf_in_if.sink     in_ch,
  tdf_out_if.source  out_ch
);
  tdf_state_t state_r, state_nxt;

  // Memories
  logic                mark_mem [PrimeLimit];
  logic [NumWidth-1:0] prime_mem [TableDepth];
  logic                mark_rd_r;
  logic [NumWidth-1:0] prime_rd_r;

  logic [NumWidth:0]     i_r, i_nxt;
  logic [TotWidth-1:0]   j_r, j_nxt;
  logic [TotWidth-1:0]   total_r, total_nxt;
  logic [ValueWidth-1:0] rem_r, rem_nxt;
  logic [ValueWidth-1:0] p_r, p_nxt;
  logic [ExpWidth-1:0]   e_r, e_nxt;
  logic [ExpWidth-1:0]   tot_r, tot_nxt;
  logic [CntWidth-1:0]   n_r, n_nxt;
  logic [2*NumWidth:0]   prod;
  logic [2*NumWidth-1:0] sq_r;
  tdf_result_t           res_r, res_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic                  mark_we;
  logic [NumWidth-1:0]   mark_wa;
  logic                  mark_wd;
  logic                  prime_we;
  logic [NumWidth-1:0]   prime_wd;
  logic [IdxWidth-1:0]   prime_ra;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [ValueWidth-1:0] div_q, div_r;
  logic [NumWidth-1:0]   i_mod;

  tdf_divider u_div (
    .clk, .rst_n,
    .start    (div_start),
    .dividend (state_r == ST_SIEVE_MOD ? ValueWidth'(i_r) : rem_r),
    .divisor  (p_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign prod  = (2*NumWidth+1)'(p_r[NumWidth-1:0]) * (2*NumWidth+1)'(i_r);
  assign i_mod = i_r[NumWidth-1:0];

  // Next state and datapath
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    total_nxt  = total_r;
    rem_nxt    = rem_r;
    p_nxt      = p_r;
    e_nxt      = e_r;
    tot_nxt    = tot_r;
    n_nxt      = n_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r;
    mark_we    = 1'b0;
    mark_wa    = i_mod;
    mark_wd    = 1'b0;
    prime_we   = 1'b0;
    prime_wd   = i_mod;
    prime_ra   = j_r[IdxWidth-1:0];
    div_start  = 1'b0;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mark_we = 1'b1;
        i_nxt   = i_r + 1'b1;
        if (i_r == (NumWidth+1)'(PrimeLimit - 1)) begin
          i_nxt     = (NumWidth+1)'(2);
          total_nxt = '0;
          state_nxt = ST_SIEVE_I;
        end
      end
      ST_SIEVE_I: begin
        // mark_rd_r holds mark of i (read issued last cycle or clear)
        if (i_r == (NumWidth+1)'(PrimeLimit)) begin
          state_nxt = ST_IDLE;
        end else begin
          if (!mark_rd_r && total_r < TotWidth'(TableDepth)) begin
            prime_we  = 1'b1;
            total_nxt = total_r + 1'b1;
          end
          j_nxt     = '0;
          state_nxt = ST_SIEVE_RD;
        end
      end
      ST_SIEVE_RD: begin
        // table entry j is read this cycle
        if (j_r >= total_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SIEVE_CHK;
        end else begin
          state_nxt = ST_SIEVE_LD;
        end
      end
      ST_SIEVE_LD: begin
        p_nxt     = ValueWidth'(prime_rd_r);
        state_nxt = ST_SIEVE_MOD;
      end
      ST_SIEVE_CHK: begin
        // mark of the new i is read this cycle
        state_nxt = ST_SIEVE_I;
      end
      ST_SIEVE_MOD: begin
        if (prod >= (2*NumWidth+1)'(PrimeLimit)) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SIEVE_CHK;
        end else if (!div_done && !div_busy) begin
          div_start = 1'b1;
          mark_we   = 1'b1;
          mark_wa   = prod[NumWidth-1:0];
          mark_wd   = 1'b1;
        end else if (div_done) begin
          if (div_r == '0) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_SIEVE_CHK;
          end else begin
            j_nxt     = j_r + 1'b1;
            prime_ra  = IdxWidth'(j_r + 1'b1);
            state_nxt = ST_SIEVE_RD;
          end
        end
      end
      ST_IDLE: begin
        // fetch the first table prime
        prime_ra = '0;
        if (in_ch.valid) begin
          rem_nxt = in_ch.value;
          j_nxt   = '0;
          tot_nxt = '0;
          n_nxt   = '0;
          if (in_ch.value <= ValueWidth'(1)) begin
            res_nxt    = '{'0, '0, '0, 1'b1, 1'b1};
            ovalid_nxt = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (j_r >= total_r || j_r >= TotWidth'(TableDepth)) begin
          state_nxt = ST_TAIL;
        end else begin
          p_nxt     = ValueWidth'(prime_rd_r);
          e_nxt     = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_nxt = ({ValueWidth'(0), sq_r} > {(2*NumWidth)'(0), rem_r}) ? ST_TAIL
                                                                        : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_r == '0) begin
            rem_nxt   = div_q;
            e_nxt     = e_r + 1'b1;
            state_nxt = ST_DIVIDE;
          end else if (e_r != '0 && n_r < CntWidth'(MaxResults)) begin
            tot_nxt   = tot_r + e_r;
            state_nxt = ST_EMIT;
          end else begin
            j_nxt     = j_r + 1'b1;
            prime_ra  = IdxWidth'(j_r + 1'b1);
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_EMIT: begin
        // wait for the output register; the result is the last when the remainder is 1
        if (!ovalid_r || out_ch.ready) begin
          if (rem_r == ValueWidth'(1)) begin
            res_nxt    = '{p_r, e_r, tot_r, 1'b0, 1'b1};
            ovalid_nxt = 1'b1;
            n_nxt      = n_r + 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            res_nxt    = '{p_r, e_r, tot_r, 1'b0, 1'b0};
            ovalid_nxt = 1'b1;
            n_nxt      = n_r + 1'b1;
            j_nxt      = j_r + 1'b1;
            prime_ra   = IdxWidth'(j_r + 1'b1);
            state_nxt  = ST_FETCH;
          end
        end
      end
      ST_TAIL: begin
        if (!ovalid_r || out_ch.ready) begin
          if (rem_r != ValueWidth'(1) && n_r < CntWidth'(MaxResults)) begin
            res_nxt    = '{rem_r, ExpWidth'(1), ExpWidth'(tot_r + 1'b1), 1'b0, 1'b1};
            ovalid_nxt = 1'b1;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_nxt) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memories and registers
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_r <= (state_r == ST_CLEAR) ? 1'b0 : mark_mem[i_nxt[NumWidth-1:0]];
    if (prime_we) prime_mem[total_r[IdxWidth-1:0]] <= prime_wd;
    prime_rd_r <= prime_mem[prime_ra];
    sq_r <= (2*NumWidth)'(prime_rd_r) * (2*NumWidth)'(prime_rd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      i_r      <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
    j_r   <= j_nxt;
    rem_r <= rem_nxt;
    p_r   <= p_nxt;
    e_r   <= e_nxt;
    tot_r <= tot_nxt;
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = ovalid_r;
  assign out_ch.prime_factor    = res_r.prime_factor;
  assign out_ch.exponent        = res_r.exponent;
  assign out_ch.total_exponents = res_r.total_exponents;
  assign out_ch.empty_res       = res_r.empty_res;
  assign out_ch.last            = res_r.last;
endmodule
`default_nettype wire

FILE: design/tdf_divider.sv
// Module: shared restoring divider, one quotient bit per cycle
`default_nettype none
module tdf_divider import tdf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ValueWidth-1:0] dividend,
  input  wire logic [ValueWidth-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [ValueWidth-1:0]      quotient,
  output logic [ValueWidth-1:0]      remainder
);
  localparam int StepWidth = $clog2(ValueWidth + 1);

  logic                  busy_r, busy_nxt;
  logic [StepWidth-1:0]  step_r, step_nxt;
  logic [ValueWidth-1:0] quo_r, quo_nxt;
  logic [ValueWidth-1:0] rem_r, rem_nxt;
  logic [ValueWidth-1:0] dvs_r, dvs_nxt;
  logic                  done_r, done_nxt;
  logic [ValueWidth:0]   trial;

  // Shift one dividend bit in, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[ValueWidth-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ValueWidth'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[ValueWidth-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ValueWidth-1:0];
        quo_nxt = {quo_r[ValueWidth-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == StepWidth'(ValueWidth - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench top: drives the factorizer, predicts factor results and checks every transfer
`default_nettype none
module tb_top import tdf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 20_000_000;
  localparam int     LongHold   = 3000;

  // Factor predictor and store of outstanding factor results
  class factor_board;
    int unsigned primes[$];
    tdf_result_t pending_factors[$];
    int errors;
    int values_taken;
    int results_seen;

    function new();
      bit marks[];
      marks = new[PrimeLimit];
      for (int i = 2; i < PrimeLimit; i++) begin
        if (!marks[i]) begin
          if (primes.size() < TableDepth) primes.push_back(i);
          for (int j = i * 2; j < PrimeLimit; j += i) marks[j] = 1'b1;
        end
      end
    endfunction

    function void push_result(logic [31:0] p, int e, int tot, bit emp);
      tdf_result_t r;
      r.prime_factor    = p;
      r.exponent        = e[ExpWidth-1:0];
      r.total_exponents = tot[ExpWidth-1:0];
      r.empty_res       = emp;
      r.last            = 1'b0;
      pending_factors.push_back(r);
    endfunction

    // Note one accepted value and queue the factors it yields
    function void note_value(logic [ValueWidth-1:0] v);
      longint unsigned rem;
      longint unsigned p;
      int e;
      int tot;
      int n;
      rem = v;
      tot = 0;
      n = 0;
      values_taken++;
      if (rem <= 1) begin
        push_result('0, 0, 0, 1'b1);
        pending_factors[$].last = 1'b1;
        return;
      end
      foreach (primes[k]) begin
        p = primes[k];
        if (p * p > rem) break;
        e = 0;
        while (rem % p == 0) begin
          rem = rem / p;
          e++;
        end
        if (e != 0 && n < MaxResults) begin
          tot += e;
          push_result(p[31:0], e, tot, 1'b0);
          n++;
        end
      end
      if (rem != 1 && n < MaxResults) begin
        tot += 1;
        push_result(rem[31:0], 1, tot, 1'b0);
        n++;
      end
      if (n > 0) pending_factors[$].last = 1'b1;
    endfunction

    // Compare one transferred result with the oldest outstanding one
    function void check_result(tdf_result_t got);
      tdf_result_t want;
      results_seen++;
      if (pending_factors.size() == 0) begin
        $error("unexpected result: prime_factor %0d", got.prime_factor);
        errors++;
        return;
      end
      want = pending_factors.pop_front();
      if (got.prime_factor !== want.prime_factor) begin
        $error("prime_factor: expected %0d, got %0d", want.prime_factor, got.prime_factor);
        errors++;
      end
      if (got.exponent !== want.exponent) begin
        $error("exponent: expected %0d, got %0d", want.exponent, got.exponent);
        errors++;
      end
      if (got.total_exponents !== want.total_exponents) begin
        $error("total_exponents: expected %0d, got %0d",
               want.total_exponents, got.total_exponents);
        errors++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tdf_in_if  in_ch ();
  tdf_out_if out_ch ();

  trial_division_factorizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  factor_board board;
  longint cycles;
  bit long_hold_req;
  bit no_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Note accepted values and check transferred results
  always @(posedge clk) begin
    tdf_result_t r;
    if (rst_n && in_ch.valid && in_ch.ready) board.note_value(in_ch.value);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.prime_factor    = out_ch.prime_factor;
      r.exponent        = out_ch.exponent;
      r.total_exponents = out_ch.total_exponents;
      r.empty_res       = out_ch.empty_res;
      r.last            = out_ch.last;
      board.check_result(r);
    end
  end

  // Result receiver: random stalls, one long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LongHold;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one value and hold it until transferred
  task automatic send_value(logic [ValueWidth-1:0] v, bit burst);
    int gap;
    gap = (no_idle || burst) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value = v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Random value built mostly from small primes so trial division stays short
  function automatic logic [ValueWidth-1:0] random_value();
    int unsigned small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                    47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    longint unsigned v;
    longint unsigned p;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return $urandom_range(0, 1000);
    v = 1;
    repeat ($urandom_range(1, 24)) begin
      p = small_primes[$urandom_range(0, small_primes.size() - 1)];
      if (v * p < 64'h1_0000_0000) v = v * p;
    end
    if (sel < 60) begin
      p = $urandom_range(2, 65535);
      if (v * p < 64'h1_0000_0000) v = v * p;
    end
    return v[31:0];
  endfunction

  // Stimulus
  initial begin
    logic [ValueWidth-1:0] directed[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd1024,
      32'h8000_0000, 32'hFFFF_FFFF, 32'd4294967291, 32'd223092870,
      32'd65536, 32'd65537, 32'd9409, 32'd30030, 32'h0000_FFFF,
      32'd4293001441, 32'd1, 32'd0, 32'd3486784401, 32'd2147483646};
    board = new();
    cycles = 0;
    long_hold_req = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_value(directed[i], 1'b0);

    for (int n = 0; n < 78; n++) begin
      // Hold the receiver off while values keep coming
      if (n == 20) long_hold_req = 1'b1;
      // Idle-free stretch
      no_idle = (n >= 45 && n < 60);
      // Drain completely before carrying on
      if (n == 75) begin
        in_ch.valid = 1'b0;
        while (board.pending_factors.size() != 0) @(negedge clk);
      end
      send_value(random_value(), n >= 20 && n < 30);
    end
    in_ch.valid = 1'b0;

    while (board.pending_factors.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("covered %0d values (zero, one, powers, primes, prime squares, nine-factor cases)",
             board.values_taken);
    $display("checked %0d results under random and long receiver stalls", board.results_seen);
    if (board.errors == 0 && board.pending_factors.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
design/tdf_pkg.sv
design/tdf_if.sv
design/tdf_divider.sv
design/trial_division_factorizer_core.sv
tb/tb_top.sv
